// ----- hw/rtl/sha_pkg.sv -----
// SHA-256 package: states, constants, round constant table, rotate helper.
package sha_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_DONE
   } sha_state_type;

   localparam logic [7:0]  PAD_BYTE     = 8'h80;
   localparam logic [5:0]  LEN_OFFSET   = 6'd56;
   localparam logic [60:0] BYTE_TOT_MAX = {61{1'b1}};

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

endpackage

// ----- hw/rtl/sha256_stream_hasher.sv -----
// SHA-256 stream hasher top level: byte buffer, round unit, padding, digest out.
//
//   channel | dir | tdata                                   | tuser
//   req     | in  | data_byte[7:0]                          | {message_end, byte_present}
//   rsp     | out | digest_part0..3 (part0 lowest 64 bits)  | length_overflow
//
// A byte that leaves the block partial is taken without a stall. A byte that
// fills a block, or a closing transaction, runs the shared round unit: ST_LOAD
// shifts the block words into the schedule window, ST_ROUND runs the 64 rounds
// and ST_ADD updates the hash words, all with req_tready low. A close then
// moves the digest into the output register in ST_DONE, after a second padding
// block when it needs one. Reset clears control state and reloads the initial
// hash words; the block buffer keeps no reset since every byte is written
// before it is read. A finished digest waits in the output register while
// bytes keep flowing; only the next close holds in ST_DONE until it is taken.
module sha256_stream_hasher
   import sha_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic [1:0]   req_tuser,   // [0] byte_present, [1] message_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [255:0] rsp_tdata,   // [63:0] part0 .. [255:192] part3
   output logic         rsp_tuser    // [0] length_overflow
);

   sha_state_type state_ff, state_in;

   logic [31:0] blk_ff [16];        // block buffer, big-endian words
   logic [31:0] blk_in [16];
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] total_ff, total_in;
   logic        ovf_ff, ovf_in;
   logic [31:0] h_ff [8];
   logic [31:0] a_ff [8];           // working variables a..h
   logic [31:0] w_ff [16];          // schedule window
   logic [6:0]  cnt_ff;
   logic        closing_ff;         // current block is padding of a close
   logic        second_ff;          // another padding block follows
   logic [255:0] dig_ff;
   logic        dig_ovf_ff;
   logic        rsp_v_ff;

   logic acc, byte_acc, wrap, dig_load;
   logic byte_pres, msg_end;
   assign byte_pres = req_tuser[0];
   assign msg_end   = req_tuser[1];
   assign acc       = req_tvalid && req_tready;
   assign byte_acc  = acc && byte_pres;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc && (wrap || msg_end)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD:  if (cnt_ff == 7'd15) state_in = ST_ROUND;
         ST_ROUND: if (cnt_ff == 7'd63) state_in = ST_ADD;
         ST_ADD: begin
            if (second_ff) state_in = ST_LOAD;
            else if (closing_ff) state_in = ST_DONE;
            else state_in = ST_IDLE;
         end
         ST_DONE:  if (dig_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      // hold the close until the previous digest has left the output register
      dig_load   = (state_ff == ST_DONE) && (!rsp_v_ff || rsp_tready);
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = dig_ff;
   assign rsp_tuser  = dig_ovf_ff;

   // byte count and fill level after the accepted transaction
   always_comb begin
      fill_in  = byte_acc ? fill_ff + 6'd1 : fill_ff;
      total_in = total_ff;
      ovf_in   = ovf_ff;
      if (byte_acc) begin
         if (total_ff == BYTE_TOT_MAX) ovf_in = 1'b1;
         else total_in = total_ff + 61'd1;
      end
   end

   assign wrap = byte_acc && (fill_in == 6'd0);   // the byte completed a block

   logic [63:0] bits;
   logic [4:0]  byte_lane, pad_lane;
   assign bits      = {total_in, 3'b000};
   assign byte_lane = {~fill_ff[1:0], 3'b000};
   assign pad_lane  = {~fill_in[1:0], 3'b000};

   // block buffer: append byte, pad on close, build the trailing block
   always_comb begin
      blk_in = blk_ff;
      if (acc) begin
         if (byte_pres) blk_in[fill_ff[5:2]][byte_lane +: 8] = req_tdata;
         if (msg_end && !wrap) begin
            blk_in[fill_in[5:2]][pad_lane +: 8] = PAD_BYTE;
            for (int j = 0; j < 16; j++) begin
               for (int k = 0; k < 4; k++) begin
                  if ({j[3:0], k[1:0]} > fill_in) blk_in[j][8*(3-k) +: 8] = 8'h00;
               end
            end
            if (fill_in < LEN_OFFSET) begin
               blk_in[14] = bits[63:32];
               blk_in[15] = bits[31:0];
            end
         end
      end else if (state_ff == ST_ADD && second_ff) begin
         // pad byte only if not yet placed
         for (int j = 0; j < 14; j++) blk_in[j] = 32'h00000000;
         if (fill_ff == 6'd0) blk_in[0] = {PAD_BYTE, 24'h000000};
         blk_in[14] = bits[63:32];
         blk_in[15] = bits[31:0];
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

   // round datapath
   logic [31:0] wcur, s0, s1, wnew, t1, t2, ch, maj, ld_word;
   assign ld_word = blk_ff[cnt_ff[3:0]];
   assign s0   = ror32(w_ff[1], 7) ^ ror32(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1   = ror32(w_ff[14], 17) ^ ror32(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign wnew = w_ff[0] + s0 + w_ff[9] + s1;
   assign wcur = w_ff[0];
   assign ch   = (a_ff[4] & a_ff[5]) ^ (~a_ff[4] & a_ff[6]);
   assign maj  = (a_ff[0] & a_ff[1]) ^ (a_ff[0] & a_ff[2]) ^ (a_ff[1] & a_ff[2]);
   assign t1   = a_ff[7] + (ror32(a_ff[4], 6) ^ ror32(a_ff[4], 11) ^ ror32(a_ff[4], 25))
               + ch + ROUND_K[cnt_ff[5:0]] + wcur;
   assign t2   = (ror32(a_ff[0], 2) ^ ror32(a_ff[0], 13) ^ ror32(a_ff[0], 22)) + maj;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         total_ff   <= '0;
         ovf_ff     <= 1'b0;
         cnt_ff     <= '0;
         closing_ff <= 1'b0;
         second_ff  <= 1'b0;
         rsp_v_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
      end else begin
         state_ff <= state_in;
         if (dig_load) rsp_v_ff <= 1'b1;
         else if (rsp_tready) rsp_v_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (acc) begin
                  fill_ff    <= fill_in;
                  total_ff   <= total_in;
                  ovf_ff     <= ovf_in;
                  closing_ff <= msg_end;
                  // a byte that filled the block pushes all padding to a second block
                  second_ff  <= msg_end && (wrap || fill_in >= LEN_OFFSET);
               end
            end
            ST_LOAD: begin
               w_ff[cnt_ff[3:0]] <= ld_word;
               if (cnt_ff == 7'd0) for (int i = 0; i < 8; i++) a_ff[i] <= h_ff[i];
               cnt_ff <= (cnt_ff == 7'd15) ? 7'd0 : cnt_ff + 7'd1;
            end
            ST_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= wnew;
               a_ff[0] <= t1 + t2;
               a_ff[1] <= a_ff[0];
               a_ff[2] <= a_ff[1];
               a_ff[3] <= a_ff[2];
               a_ff[4] <= a_ff[3] + t1;
               a_ff[5] <= a_ff[4];
               a_ff[6] <= a_ff[5];
               a_ff[7] <= a_ff[6];
               cnt_ff  <= cnt_ff + 7'd1;
            end
            ST_ADD: begin
               cnt_ff <= '0;
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + a_ff[i];
               if (second_ff) second_ff <= 1'b0;
            end
            ST_DONE: begin
               if (dig_load) begin
                  for (int i = 0; i < 4; i++) begin
                     dig_ff[64*i +: 64] <= {h_ff[2*i], h_ff[2*i+1]};
                  end
                  dig_ovf_ff <= ovf_ff;
                  for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
                  fill_ff    <= '0;
                  total_ff   <= '0;
                  ovf_ff     <= 1'b0;
                  closing_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- sim/tb_sha256_stream_hasher.sv -----
// Self-checking testbench for the SHA-256 stream hasher: predicted digests vs. block output.
module tb_sha256_stream_hasher
   import sha_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [63:0] part [4];
      logic        ovf;
   } digest_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // [7:0] data_byte
   logic [1:0]   req_tuser;   // [0] byte_present, [1] message_end
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [255:0] rsp_tdata;   // [63:0] part0 .. [255:192] part3
   logic         rsp_tuser;   // [0] length_overflow

   sha256_stream_hasher uut (.*);

   // Predictor state: chaining words, block buffer, fill level, byte count.
   logic [31:0] hash_h [8];
   logic [7:0]  blk [64];
   int unsigned fill;
   logic [60:0] msg_bytes;
   logic        msg_ovf;

   digest_type  digest_q [$];
   int          errors;
   int          idle_cycles;
   bit          rsp_hold;    // long receiver hold-off request
   bit          stall_mode;  // random receiver stalls enabled

   initial begin
      clock = 1'b0;
   end
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] rotr(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   // Run one 64-round compression over blk into hash_h.
   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) begin
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                  hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
      for (int i = 0; i < 64; i++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + ROUND_K[i] + w[i];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
      hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++) hash_h[i] = INIT_H[i];
      fill = 0;
      msg_bytes = '0;
      msg_ovf = 1'b0;
   endtask

   // Advance the predictor by one accepted transaction; queue a digest on close.
   task automatic hash_transaction(logic [7:0] data, logic present, logic last);
      logic [63:0] bits;
      digest_type  dg;
      if (present) begin
         blk[fill] = data;
         fill = (fill + 1) % 64;
         if (fill == 0) compress_block();
         if (msg_bytes == BYTE_TOT_MAX) msg_ovf = 1'b1;
         else msg_bytes++;
      end
      if (!last) return;
      blk[fill] = PAD_BYTE;
      fill++;
      if (fill > LEN_OFFSET) begin
         for (int i = fill; i < 64; i++) blk[i] = 8'h00;
         compress_block();
         fill = 0;
      end
      for (int i = fill; i < LEN_OFFSET; i++) blk[i] = 8'h00;
      bits = {msg_bytes, 3'b000};
      for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
      compress_block();
      for (int i = 0; i < 4; i++) dg.part[i] = {hash_h[2*i], hash_h[2*i+1]};
      dg.ovf = msg_ovf;
      digest_q.push_back(dg);
      restart_message();
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Random gap: mostly none or short, sometimes long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   int send_gap_en;

   // Offer one transaction and hold it until the block accepts it.
   // Drop tvalid only when a gap follows, so back-to-back offers stay valid.
   task automatic send_byte(logic [7:0] data, logic present, logic last);
      int gap;
      gap = send_gap_en ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= {last, present};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hash_transaction(data, present, last);
   endtask

   task automatic send_message(int len, bit empty_close);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom), 1'b1, (i == len - 1) && !empty_close);
      end
      if (empty_close || len == 0) send_byte(8'($urandom), 1'b0, 1'b1);
   endtask

   // Stop offering and wait until every predicted digest has been checked.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, or a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold) begin
         rsp_tready <= 1'b0;
      end else if (stall_mode) begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check each accepted digest against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_q.size() == 0) begin
            report_mismatch("unexpected digest_part0", rsp_tdata[63:0], 64'h0);
         end else begin
            digest_type want;
            want = digest_q.pop_front();
            for (int i = 0; i < 4; i++) begin
               if (rsp_tdata[64*i +: 64] !== want.part[i]) begin
                  report_mismatch($sformatf("digest_part%0d", i), rsp_tdata[64*i +: 64],
                                  want.part[i]);
               end
            end
            if (rsp_tuser !== want.ovf) report_mismatch("length_overflow", rsp_tuser, want.ovf);
         end
      end
   end

   // Watchdog: abort when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 5000) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Known-answer style edges: empty, idle items, pad boundaries.
   task automatic test_directed();
      send_byte(8'h00, 1'b0, 1'b1);                 // empty message
      send_byte(8'hff, 1'b0, 1'b0);                 // idle item
      send_byte(8'h61, 1'b1, 1'b0);
      send_byte(8'h62, 1'b1, 1'b0);
      send_byte(8'h63, 1'b1, 1'b1);                 // "abc"
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hff, 1'b1, 1'b0);
      send_byte(8'h55, 1'b0, 1'b0);
      send_byte(8'haa, 1'b0, 1'b1);                 // bytes then empty close
      send_message(55, 0);                          // single padding block
      send_message(56, 0);                          // two padding blocks
      send_message(63, 0);
      send_message(64, 0);                          // exact block then pad block
      send_message(64, 1);
   endtask

   // Mostly well-formed messages of random length, with noise sprinkled in.
   task automatic test_random_messages(int items);
      int sent, len;
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
         if ($urandom_range(0, 4) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
         send_message(len, $urandom_range(0, 3) == 0);
         sent += len + 1;
      end
   endtask

   // Hold the receiver off while digests pile up and the input stalls.
   task automatic test_backpressure();
      rsp_hold = 1'b1;
      fork
         begin
            repeat (800) @(posedge clock);
            rsp_hold = 1'b0;
         end
         begin
            for (int i = 0; i < 6; i++) send_message($urandom_range(0, 3), 0);
         end
      join
      wait_drained();
   endtask

   initial begin
      errors = 0;
      idle_cycles = 0;
      rsp_hold = 1'b0;
      stall_mode = 1'b0;
      send_gap_en = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      restart_message();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      stall_mode = 1'b1;
      send_gap_en = 1;
      test_random_messages(300);
      wait_drained();                               // sender pauses until drained
      test_backpressure();
      send_gap_en = 0;
      stall_mode = 1'b0;
      test_random_messages(150);                    // back-to-back, no idling
      stall_mode = 1'b1;
      send_gap_en = 1;
      test_random_messages(200);

      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/sha_pkg.sv
hw/rtl/sha256_stream_hasher.sv
sim/tb_sha256_stream_hasher.sv
